/* design/dmsp_pkg.sv */
// ----------------------------------------------------------------------------
// dmsp_pkg
// shared types, register indexes, reset values and helpers for the debounced
// mode selector with pwm output
// ----------------------------------------------------------------------------
package dmsp_pkg;

   localparam int CsrDataWidth  = 36;
   localparam int CsrIndexWidth = 3;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_TICK_PERIOD    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DUTY_WORDS     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE_COUNT = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RELEASE_GUARD  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_SETTLE_MS      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_BOOT_STEP_MS   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_BOOT_GAP_MS    = 3'd6;

   // register reset values
   localparam logic [5:0]  TICK_PERIOD_RESET    = 6'd50;
   localparam logic [35:0] DUTY_WORDS_RESET     = 36'd48929514048;
   localparam logic [7:0]  DEBOUNCE_COUNT_RESET = 8'd30;
   localparam logic [9:0]  RELEASE_GUARD_RESET  = 10'd500;
   localparam logic [7:0]  SETTLE_MS_RESET      = 8'd20;
   localparam logic [7:0]  BOOT_STEP_MS_RESET   = 8'd120;
   localparam logic [7:0]  BOOT_GAP_MS_RESET    = 8'd150;

   // mode code meaning no button pressed
   localparam logic [2:0] BUTTON_NONE = 3'd7;
   localparam logic [5:0] LEDS_DARK   = 6'h3F;

   typedef struct packed {
      logic [5:0]  tick_period;
      logic [35:0] duty_words;
      logic [7:0]  debounce_count;
      logic [9:0]  release_guard_ms;
      logic [7:0]  settle_ms;
      logic [7:0]  boot_step_ms;
      logic [7:0]  boot_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic       pwm_level;
      logic [5:0] led_drive_n;
      logic [2:0] current_mode;
      logic [1:0] phase;
   } rsp_type;

   // active-low drive with only the led of the given mode lit
   function automatic logic [5:0] one_led(input logic [2:0] mode);
      logic [7:0] onehot;
      onehot = 8'd1 << mode;
      return ~onehot[5:0];
   endfunction

   // duty of a mode from the packed duty word, mode codes wrap every six
   function automatic logic [5:0] duty_of(input logic [35:0] words, input logic [2:0] mode);
      logic [5:0] duty;
      case (mode)
         3'd0:    duty = words[5:0];
         3'd1:    duty = words[11:6];
         3'd2:    duty = words[17:12];
         3'd3:    duty = words[23:18];
         3'd4:    duty = words[29:24];
         3'd5:    duty = words[35:30];
         3'd6:    duty = words[5:0];
         default: duty = words[11:6];
      endcase
      return duty;
   endfunction

endpackage

/* design/dmsp_core.sv */
// ----------------------------------------------------------------------------
// dmsp_core
// pwm counter, millisecond sequencer and button debounce; one tick per advance
// ----------------------------------------------------------------------------
module dmsp_core #(
   parameter int NUM_MODES = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [5:0]        buttons_n,
   input  dmsp_pkg::cfg_type cfg,
   output dmsp_pkg::rsp_type result
);

   typedef enum logic [1:0] {
      PH_BOOT   = 2'd0,
      PH_RUN    = 2'd1,
      PH_WAIT   = 2'd2,
      PH_SETTLE = 2'd3
   } phase_type;

   localparam logic [2:0] LastBoot = 3'(NUM_MODES);

   logic [5:0] pwm_count_ff,   pwm_count_in;
   logic [5:0] active_duty_ff, active_duty_in;
   phase_type  phase_ff,       phase_in;
   logic [9:0] ms_timer_ff,    ms_timer_in;
   logic [2:0] boot_index_ff,  boot_index_in;
   logic [2:0] mode_ff,        mode_in;
   logic [2:0] candidate_ff,   candidate_in;
   logic [7:0] hold_ff,        hold_in;
   logic [5:0] led_ff,         led_in;

   logic [2:0] button;
   logic [6:0] count_inc;
   logic [9:0] timer_inc;
   logic [7:0] hold_inc;
   logic [7:0] boot_limit;
   logic [5:0] leds;

   // lowest pressed button among the mode buttons
   always_comb begin
      button = dmsp_pkg::BUTTON_NONE;
      for (int i = NUM_MODES - 1; i >= 0; i--) begin
         if (!buttons_n[i]) begin
            button = 3'(i);
         end
      end
   end

   assign count_inc  = {1'b0, pwm_count_ff} + 7'd1;
   assign timer_inc  = ms_timer_ff + 10'd1;
   assign hold_inc   = (hold_ff == 8'hFF) ? hold_ff : hold_ff + 8'd1;
   assign boot_limit = (boot_index_ff < LastBoot) ? cfg.boot_step_ms : cfg.boot_gap_ms;

   always_comb begin
      pwm_count_in   = pwm_count_ff;
      active_duty_in = active_duty_ff;
      phase_in       = phase_ff;
      ms_timer_in    = ms_timer_ff;
      boot_index_in  = boot_index_ff;
      mode_in        = mode_ff;
      candidate_in   = candidate_ff;
      hold_in        = hold_ff;
      led_in         = led_ff;

      if (count_inc >= {1'b0, cfg.tick_period}) begin
         // counter wrap: one millisecond step
         pwm_count_in = '0;
         case (phase_ff)
            PH_BOOT: begin
               ms_timer_in = timer_inc;
               if (timer_inc >= {2'b00, boot_limit}) begin
                  ms_timer_in = '0;
                  if (boot_index_ff < LastBoot) begin
                     boot_index_in = boot_index_ff + 3'd1;
                  end else begin
                     phase_in     = PH_RUN;
                     mode_in      = '0;
                     led_in       = dmsp_pkg::one_led(3'd0);
                     candidate_in = dmsp_pkg::BUTTON_NONE;
                     hold_in      = '0;
                  end
               end
            end
            PH_RUN: begin
               if (button != dmsp_pkg::BUTTON_NONE && button != mode_ff) begin
                  if (button == candidate_ff) begin
                     hold_in = hold_inc;
                     if (hold_inc >= cfg.debounce_count) begin
                        mode_in        = button;
                        active_duty_in = dmsp_pkg::duty_of(cfg.duty_words, button);
                        led_in         = dmsp_pkg::one_led(button);
                        hold_in        = '0;
                        phase_in       = PH_WAIT;
                        ms_timer_in    = '0;
                     end
                  end else begin
                     candidate_in = button;
                     hold_in      = 8'd1;
                  end
               end else begin
                  candidate_in = dmsp_pkg::BUTTON_NONE;
                  hold_in      = '0;
               end
            end
            PH_WAIT: begin
               if (button == dmsp_pkg::BUTTON_NONE ||
                   ms_timer_ff >= cfg.release_guard_ms) begin
                  phase_in    = PH_SETTLE;
                  ms_timer_in = '0;
               end else begin
                  ms_timer_in = timer_inc;
               end
            end
            default: begin
               ms_timer_in = timer_inc;
               if (timer_inc >= {2'b00, cfg.settle_ms}) begin
                  phase_in    = PH_RUN;
                  ms_timer_in = '0;
               end
            end
         endcase
      end else begin
         pwm_count_in = count_inc[5:0];
      end
   end

   // result shows the state after this tick
   always_comb begin
      if (phase_in == PH_BOOT) begin
         leds = (boot_index_in < LastBoot) ? dmsp_pkg::one_led(boot_index_in)
                                           : dmsp_pkg::LEDS_DARK;
      end else begin
         leds = led_in;
      end
      result.pwm_level    = (pwm_count_in < active_duty_in);
      result.led_drive_n  = leds;
      result.current_mode = mode_in;
      result.phase        = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff   <= '0;
         active_duty_ff <= dmsp_pkg::DUTY_WORDS_RESET[5:0];
         phase_ff       <= PH_BOOT;
         ms_timer_ff    <= '0;
         boot_index_ff  <= '0;
         mode_ff        <= '0;
         candidate_ff   <= dmsp_pkg::BUTTON_NONE;
         hold_ff        <= '0;
         led_ff         <= dmsp_pkg::LEDS_DARK;
      end else if (advance) begin
         pwm_count_ff   <= pwm_count_in;
         active_duty_ff <= active_duty_in;
         phase_ff       <= phase_in;
         ms_timer_ff    <= ms_timer_in;
         boot_index_ff  <= boot_index_in;
         mode_ff        <= mode_in;
         candidate_ff   <= candidate_in;
         hold_ff        <= hold_in;
         led_ff         <= led_in;
      end
   end

`ifndef SYNTHESIS
   a_boot_mode_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BOOT |-> mode_ff == 3'd0)
      else $error("mode changed during boot scan");

   a_led_follows_mode: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_BOOT |-> led_ff == dmsp_pkg::one_led(mode_ff))
      else $error("led drive out of step with mode");

   a_mode_in_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff < 3'(NUM_MODES))
      else $error("mode out of range");
`endif

endmodule

/* design/debounced_mode_selector_pwm.sv */
// ----------------------------------------------------------------------------
// debounced_mode_selector_pwm
// Debounced radio-button mode selector with a pwm level output. Each request
// is one pwm tick carrying the six active-low button levels; each response is
// the pwm level, active-low led drives, current mode and phase after that
// tick. A request passes an input register and the tick logic into a response
// register; the input register holds it until the response register is free
// or being drained, and a new request is taken every cycle while responses
// are drained. The limit of one tick per cycle is set by the single state
// update in the tick logic.
// Configuration writes are taken at any time but belong to idle periods; a
// new duty word only takes effect at the next mode change.
// ----------------------------------------------------------------------------
module debounced_mode_selector_pwm #(
   parameter int NUM_MODES = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   // requests
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [5:0]                         req_buttons_n,
   // responses
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_pwm_level,
   output logic [5:0]                         rsp_led_drive_n,
   output logic [2:0]                         rsp_current_mode,
   output logic [1:0]                         rsp_phase,
   // configuration writes
   input  logic                               csr_write_en,
   input  logic [dmsp_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [dmsp_pkg::CsrDataWidth-1:0]  csr_data
);

   dmsp_pkg::cfg_type cfg_ff;

   logic              in_valid_ff;
   logic [5:0]        in_buttons_ff;
   logic              out_valid_ff;
   dmsp_pkg::rsp_type out_ff;
   dmsp_pkg::rsp_type tick_result;
   logic              advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period      <= dmsp_pkg::TICK_PERIOD_RESET;
         cfg_ff.duty_words       <= dmsp_pkg::DUTY_WORDS_RESET;
         cfg_ff.debounce_count   <= dmsp_pkg::DEBOUNCE_COUNT_RESET;
         cfg_ff.release_guard_ms <= dmsp_pkg::RELEASE_GUARD_RESET;
         cfg_ff.settle_ms        <= dmsp_pkg::SETTLE_MS_RESET;
         cfg_ff.boot_step_ms     <= dmsp_pkg::BOOT_STEP_MS_RESET;
         cfg_ff.boot_gap_ms      <= dmsp_pkg::BOOT_GAP_MS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            dmsp_pkg::CSR_TICK_PERIOD:    cfg_ff.tick_period      <= csr_data[5:0];
            dmsp_pkg::CSR_DUTY_WORDS:     cfg_ff.duty_words       <= csr_data[35:0];
            dmsp_pkg::CSR_DEBOUNCE_COUNT: cfg_ff.debounce_count   <= csr_data[7:0];
            dmsp_pkg::CSR_RELEASE_GUARD:  cfg_ff.release_guard_ms <= csr_data[9:0];
            dmsp_pkg::CSR_SETTLE_MS:      cfg_ff.settle_ms        <= csr_data[7:0];
            dmsp_pkg::CSR_BOOT_STEP_MS:   cfg_ff.boot_step_ms     <= csr_data[7:0];
            dmsp_pkg::CSR_BOOT_GAP_MS:    cfg_ff.boot_gap_ms      <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // tick moves from the input register to the response register when the
   // response slot is empty or being drained this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_buttons_ff <= req_buttons_n;
      end
   end

   dmsp_core #(
      .NUM_MODES (NUM_MODES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .buttons_n (in_buttons_ff),
      .cfg       (cfg_ff),
      .result    (tick_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= tick_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pwm_level    = out_ff.pwm_level;
   assign rsp_led_drive_n  = out_ff.led_drive_n;
   assign rsp_current_mode = out_ff.current_mode;
   assign rsp_phase        = out_ff.phase;

`ifndef SYNTHESIS
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("request refused with empty input register");

   a_request_captured: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted request lost");

   a_tick_delivered: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("tick result not held for response");

   a_stall_holds_tick: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff && $stable(in_buttons_ff))
      else $error("pending tick dropped during stall");
`endif

endmodule
